// ===== hdl/keyed_bucket_list_table_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Keyed bucket list table assertion macros
// Shared assertion wrappers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef KEYED_BUCKET_LIST_TABLE_UNIT_DEFINES_SVH
`define KEYED_BUCKET_LIST_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define KBLT_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyed bucket list table assertion failed");

`define KBLT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyed bucket list table assertion failed");

`else

`define KBLT_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`define KBLT_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/kblt_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyed bucket list table package
// Modes, status codes and the queued command type.
// ----------------------------------------------------------------------------
package kblt_pkg;

  localparam int KEY_W    = 32;
  localparam int IDX_W    = 12;
  localparam int HOME_W   = 16;
  localparam int EPOCH_W  = 4;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_NEXT   = 2'd2,
    MODE_MARK   = 2'd3
  } mode_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef struct packed {
    mode_t              mode;
    logic [KEY_W-1:0]   key;
    logic [IDX_W-1:0]   entry_index;
    logic [HOME_W-1:0]  home;
  } item_t;

endpackage

// ===== hdl/keyed_bucket_list_table_unit.sv =====
// ----------------------------------------------------------------------------
// Keyed bucket list table unit
// Linear probing key table with per-key lists in an entry arena.
// ----------------------------------------------------------------------------
// Each command is answered by exactly one response. The front end registers
// a command and hands it to the queue once its home slot is known and the
// queue has room; it takes no new command before that. When TABLE_SLOTS is
// a power of two the home slot comes from key bits; otherwise a reciprocal
// multiplication gives a quotient estimate and then the remainder. The back
// end handles one command at a time and takes the next only after the
// response has been taken; every probe is one registered read of the slot
// memory. Alloc probes to a free or matching slot, a successful lookup also
// reads the head entry, next reads the link and then the entry (only the
// link at the end of a list) and mark consumed answers at once. After reset,
// and on every fifteenth frame clear, the back end sweeps the whole slot
// memory before it continues; commands queue meanwhile.
module keyed_bucket_list_table_unit #(
  parameter int TABLE_SLOTS   = 1024,
  parameter int ARENA_ENTRIES = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [1:0]                  mode,
  input  logic [kblt_pkg::KEY_W-1:0]  key,
  input  logic [kblt_pkg::IDX_W-1:0]  entry_index,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [1:0]                  status,
  output logic [kblt_pkg::IDX_W-1:0]  index,
  output logic [kblt_pkg::KEY_W-1:0]  node_key
);

  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  kblt_pkg::item_t  push_item;
  kblt_pkg::item_t  q_item;

  kblt_front #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .mode        (mode),
    .key         (key),
    .entry_index (entry_index),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  kblt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_valid),
    .head_item (q_item)
  );

  kblt_back #(
    .TABLE_SLOTS   (TABLE_SLOTS),
    .ARENA_ENTRIES (ARENA_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .index     (index),
    .node_key  (node_key)
  );

endmodule

// ===== hdl/kblt_front.sv =====
// ----------------------------------------------------------------------------
// Keyed bucket list table front end
// Accepts commands and computes the home slot of the key.
// ----------------------------------------------------------------------------
module kblt_front #(
  parameter int TABLE_SLOTS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [1:0]                  mode,
  input  logic [kblt_pkg::KEY_W-1:0]  key,
  input  logic [kblt_pkg::IDX_W-1:0]  entry_index,
  input  logic                        q_full,
  output logic                        push,
  output kblt_pkg::item_t             push_item
);

  localparam int  HW      = $clog2(TABLE_SLOTS);
  localparam bit  IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

  logic                        held;
  kblt_pkg::mode_t             hold_mode;
  logic [kblt_pkg::KEY_W-1:0]  hold_key;
  logic [kblt_pkg::IDX_W-1:0]  hold_index;
  logic [HW-1:0]               home;
  logic                        done;
  logic                        accept;

  assign req_stall = held;
  assign accept    = req_valid && !held;
  assign push      = held && done && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_mode  <= kblt_pkg::mode_t'(mode);
      hold_key   <= key;
      hold_index <= entry_index;
    end
  end

  generate
    if (IS_POW2) begin : g_mask
      assign home = hold_key[HW+1:2];
      assign done = 1'b1;
    end else begin : g_rem
      // The quotient estimate from the truncated reciprocal is low by at most
      // one, so a single compare and subtract finishes the remainder.
      localparam logic [31:0] RECIP = 32'((64'd1 << 30) / 64'(TABLE_SLOTS));

      logic [29:0] quo;
      logic [61:0] prod;
      logic [29:0] q_est;
      logic [29:0] r_est;
      logic [1:0]  step;

      assign quo  = hold_key[31:2];
      assign prod = 62'(quo) * 62'(RECIP);
      assign done = step == 2'd2;
      assign home = HW'((r_est >= 30'(TABLE_SLOTS)) ? r_est - 30'(TABLE_SLOTS) : r_est);

      always_ff @(posedge clk) begin
        if (accept) begin
          step <= 2'd0;
        end else if (held && !done) begin
          step <= step + 2'd1;
          if (step == 2'd0) begin
            q_est <= prod[59:30];
          end else begin
            r_est <= quo - 30'(q_est * 30'(TABLE_SLOTS));
          end
        end
      end
    end
  endgenerate

  always_comb begin
    push_item.mode        = hold_mode;
    push_item.key         = hold_key;
    push_item.entry_index = hold_index;
    push_item.home        = kblt_pkg::HOME_W'(home);
  end

endmodule

// ===== hdl/kblt_queue.sv =====
// ----------------------------------------------------------------------------
// Keyed bucket list table command queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module kblt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  kblt_pkg::item_t  push_item,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output kblt_pkg::item_t  head_item
);

  kblt_pkg::item_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;

  assign full      = fill == 2'd2;
  assign nonempty  = fill != 2'd0;
  assign head_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== hdl/kblt_back.sv =====
// ----------------------------------------------------------------------------
// Keyed bucket list table back end
// Probes the slot memory, maintains the entry arena and returns results.
// ----------------------------------------------------------------------------
`include "keyed_bucket_list_table_unit_defines.svh"

module kblt_back #(
  parameter int TABLE_SLOTS   = 1024,
  parameter int ARENA_ENTRIES = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  kblt_pkg::item_t             q_item,
  output logic                        q_pop,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [1:0]                  status,
  output logic [kblt_pkg::IDX_W-1:0]  index,
  output logic [kblt_pkg::KEY_W-1:0]  node_key
);

  localparam int HW = $clog2(TABLE_SLOTS);
  localparam int NW = $clog2(TABLE_SLOTS + 1);
  localparam int EW = $clog2(ARENA_ENTRIES);
  localparam int CW = $clog2(ARENA_ENTRIES + 1);
  localparam int PW = kblt_pkg::EPOCH_W;
  localparam int RW = PW + kblt_pkg::KEY_W + EW;

  typedef enum logic [7:0] {
    S_SWEEP     = 8'b0000_0001,
    S_IDLE      = 8'b0000_0010,
    S_PROBE_RD  = 8'b0000_0100,
    S_PROBE_CHK = 8'b0000_1000,
    S_LINK_RD   = 8'b0001_0000,
    S_LINK_CHK  = 8'b0010_0000,
    S_NODE_RD   = 8'b0100_0000,
    S_NODE_CHK  = 8'b1000_0000
  } state_t;

  state_t                      state;
  kblt_pkg::mode_t             cur_mode;
  logic [kblt_pkg::KEY_W-1:0]  cur_key;
  logic                        loaded;
  logic [HW-1:0]               h;
  logic [NW-1:0]               n;
  logic [EW-1:0]               ent_addr;
  logic [PW-1:0]               epoch;
  logic [PW-1:0]               epoch_next;
  logic [CW-1:0]               count;
  logic                        consumed;
  logic [HW-1:0]               sweep_idx;

  logic [RW-1:0]               slot_mem [TABLE_SLOTS];
  logic [RW-1:0]               slot_rd;
  logic [kblt_pkg::KEY_W-1:0]  node_mem [ARENA_ENTRIES];
  logic [kblt_pkg::KEY_W-1:0]  node_rd;
  logic [EW:0]                 link_mem [ARENA_ENTRIES];
  logic [EW:0]                 link_rd;

  logic [kblt_pkg::KEY_W-1:0]  anc;
  logic [EW-1:0]               old_head;
  logic                        hit;
  logic                        last_probe;
  logic [HW-1:0]               h_inc;
  logic                        alloc_wr;
  logic                        slot_we;
  logic [HW-1:0]               slot_wa;
  logic [RW-1:0]               slot_wd;

  assign epoch_next = epoch + PW'(1);
  assign q_pop      = (state == S_IDLE) && q_valid && !rsp_valid;

  always_comb begin
    if (slot_rd[RW-1 -: PW] == epoch) begin
      anc = slot_rd[EW +: kblt_pkg::KEY_W];
    end else begin
      anc = '0;
    end
    old_head   = slot_rd[EW-1:0];
    hit        = (anc == '0) || (anc == cur_key);
    last_probe = n == NW'(TABLE_SLOTS - 1);
    h_inc      = (h == HW'(TABLE_SLOTS - 1)) ? '0 : h + HW'(1);
    alloc_wr   = (state == S_PROBE_CHK) && hit && (cur_mode == kblt_pkg::MODE_ALLOC);
    slot_we    = (state == S_SWEEP) || alloc_wr;
    slot_wa    = (state == S_SWEEP) ? sweep_idx : h;
    slot_wd    = (state == S_SWEEP) ? '0 : {epoch, cur_key, count[EW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd <= slot_mem[h];
  end

  always_ff @(posedge clk) begin
    if (alloc_wr) begin
      node_mem[count[EW-1:0]] <= cur_key;
      link_mem[count[EW-1:0]] <= {anc != '0, old_head};
    end
    node_rd <= node_mem[ent_addr];
    link_rd <= link_mem[ent_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      sweep_idx <= '0;
      epoch     <= '0;
      count     <= '0;
      consumed  <= 1'b0;
      loaded    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_SWEEP: begin
          sweep_idx <= sweep_idx + HW'(1);
          if (sweep_idx == HW'(TABLE_SLOTS - 1)) begin
            epoch <= PW'(1);
            state <= loaded ? S_PROBE_RD : S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            cur_mode <= q_item.mode;
            cur_key  <= q_item.key;
            h        <= HW'(q_item.home);
            n        <= '0;
            unique case (q_item.mode)
              kblt_pkg::MODE_ALLOC: begin
                if (consumed) begin
                  consumed <= 1'b0;
                  count    <= '0;
                  epoch    <= epoch_next;
                  loaded   <= 1'b1;
                  if (epoch_next == '0) begin
                    sweep_idx <= '0;
                    state     <= S_SWEEP;
                  end else begin
                    state <= S_PROBE_RD;
                  end
                end else if (count >= CW'(ARENA_ENTRIES)) begin
                  rsp_valid <= 1'b1;
                  status    <= kblt_pkg::ST_FULL;
                  index     <= '0;
                  node_key  <= '0;
                end else begin
                  state <= S_PROBE_RD;
                end
              end
              kblt_pkg::MODE_LOOKUP: begin
                if (count == '0) begin
                  rsp_valid <= 1'b1;
                  status    <= kblt_pkg::ST_NONE;
                  index     <= '0;
                  node_key  <= '0;
                end else begin
                  state <= S_PROBE_RD;
                end
              end
              kblt_pkg::MODE_NEXT: begin
                if (32'(q_item.entry_index) >= 32'(ARENA_ENTRIES)) begin
                  rsp_valid <= 1'b1;
                  status    <= kblt_pkg::ST_NONE;
                  index     <= '0;
                  node_key  <= '0;
                end else begin
                  ent_addr <= EW'(q_item.entry_index);
                  state    <= S_LINK_RD;
                end
              end
              kblt_pkg::MODE_MARK: begin
                if (count != '0) begin
                  consumed <= 1'b1;
                end
                rsp_valid <= 1'b1;
                status    <= kblt_pkg::ST_OK;
                index     <= '0;
                node_key  <= '0;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_PROBE_RD: begin
          state <= S_PROBE_CHK;
        end
        S_PROBE_CHK: begin
          if (hit) begin
            if (cur_mode == kblt_pkg::MODE_ALLOC) begin
              count     <= count + CW'(1);
              rsp_valid <= 1'b1;
              status    <= kblt_pkg::ST_OK;
              index     <= kblt_pkg::IDX_W'(count[EW-1:0]);
              node_key  <= cur_key;
              loaded    <= 1'b0;
              state     <= S_IDLE;
            end else if (anc == '0) begin
              rsp_valid <= 1'b1;
              status    <= kblt_pkg::ST_NONE;
              index     <= '0;
              node_key  <= '0;
              loaded    <= 1'b0;
              state     <= S_IDLE;
            end else begin
              ent_addr <= old_head;
              state    <= S_NODE_RD;
            end
          end else if (last_probe) begin
            rsp_valid <= 1'b1;
            status    <= (cur_mode == kblt_pkg::MODE_ALLOC) ? kblt_pkg::ST_FULL
                                                            : kblt_pkg::ST_NONE;
            index     <= '0;
            node_key  <= '0;
            loaded    <= 1'b0;
            state     <= S_IDLE;
          end else begin
            h     <= h_inc;
            n     <= n + NW'(1);
            state <= S_PROBE_RD;
          end
        end
        S_LINK_RD: begin
          state <= S_LINK_CHK;
        end
        S_LINK_CHK: begin
          if (!link_rd[EW]) begin
            rsp_valid <= 1'b1;
            status    <= kblt_pkg::ST_NONE;
            index     <= '0;
            node_key  <= '0;
            state     <= S_IDLE;
          end else begin
            ent_addr <= link_rd[EW-1:0];
            state    <= S_NODE_RD;
          end
        end
        S_NODE_RD: begin
          state <= S_NODE_CHK;
        end
        S_NODE_CHK: begin
          rsp_valid <= 1'b1;
          status    <= kblt_pkg::ST_OK;
          index     <= kblt_pkg::IDX_W'(ent_addr);
          node_key  <= node_rd;
          loaded    <= 1'b0;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `KBLT_ASSERT_IMPLIES(a_rsp_only_idle, clk, rst, rsp_valid, state == S_IDLE)
  `KBLT_ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, count <= CW'(ARENA_ENTRIES))
  `KBLT_ASSERT_IMPLIES(a_epoch_live, clk, rst, state != S_SWEEP, epoch != '0)
  `KBLT_ASSERT_IMPLIES(a_fail_zero, clk, rst, rsp_valid && status != kblt_pkg::ST_OK, index == '0 && node_key == '0)
  `KBLT_ASSERT_NEXT(a_mark_arms, clk, rst, q_pop && q_item.mode == kblt_pkg::MODE_MARK && count != '0, consumed)

endmodule

// ===== test/keyed_bucket_list_table_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyed bucket list table unit testbench
// Drives lookup, alloc, next and mark transactions into the table and checks
// every response against a predictor of the probing table and entry arena.
// Directed tests cover the corner cases, then random traffic runs with
// changing back pressure.
// ----------------------------------------------------------------------------
module keyed_bucket_list_table_unit_tb;

  localparam int SLOTS   = 1024;
  localparam int ENTRIES = 4096;

  typedef struct {
    logic [1:0]                 status;
    logic [kblt_pkg::IDX_W-1:0] index;
    logic [kblt_pkg::KEY_W-1:0] node_key;
  } answer_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       req_valid = 1'b0;
  logic                       req_stall;
  logic [1:0]                 mode = kblt_pkg::MODE_MARK;
  logic [kblt_pkg::KEY_W-1:0] key = '0;
  logic [kblt_pkg::IDX_W-1:0] entry_index = '0;
  logic                       rsp_valid;
  logic                       rsp_stall = 1'b0;
  logic [1:0]                 status;
  logic [kblt_pkg::IDX_W-1:0] index;
  logic [kblt_pkg::KEY_W-1:0] node_key;

  logic [kblt_pkg::KEY_W-1:0] anchor_mem [SLOTS];
  logic [kblt_pkg::IDX_W-1:0] head_mem [SLOTS];
  logic [kblt_pkg::KEY_W-1:0] node_mem [ENTRIES];
  logic [kblt_pkg::IDX_W-1:0] link_mem [ENTRIES];
  logic                       link_live [ENTRIES];
  int                         used_entries;
  int                         written_entries;
  logic                       clear_armed;

  answer_t                    pending_answers [$];
  logic [kblt_pkg::KEY_W-1:0] key_pool [48];
  int                         errors = 0;
  int                         sent = 0;
  int                         checked = 0;
  int                         tx_idle = 0;
  int                         rx_idle = 0;
  logic                       rx_hold = 1'b0;

  keyed_bucket_list_table_unit i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .mode(mode), .key(key), .entry_index(entry_index),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .index(index), .node_key(node_key)
  );

  always #1 clk = ~clk;

  function automatic bit find_slot(input logic [kblt_pkg::KEY_W-1:0] k, output int slot);
    int h;
    h = (k >> 2) % SLOTS;
    for (int n = 0; n < SLOTS; n++) begin
      if (anchor_mem[h] == '0 || anchor_mem[h] == k) begin
        slot = h;
        return 1'b1;
      end
      h = (h + 1) % SLOTS;
    end
    slot = 0;
    return 1'b0;
  endfunction

  function automatic answer_t table_answer(input kblt_pkg::mode_t m,
                                           input logic [kblt_pkg::KEY_W-1:0] k,
                                           input logic [kblt_pkg::IDX_W-1:0] ei);
    answer_t a;
    int      slot;
    int      e;
    a = '{kblt_pkg::ST_OK, '0, '0};
    case (m)
      kblt_pkg::MODE_ALLOC: begin
        if (clear_armed) begin
          foreach (anchor_mem[i]) anchor_mem[i] = '0;
          used_entries = 0;
          clear_armed = 1'b0;
        end
        if (used_entries >= ENTRIES || !find_slot(k, slot)) begin
          a.status = kblt_pkg::ST_FULL;
        end else begin
          e = used_entries;
          link_live[e] = (anchor_mem[slot] != '0);
          if (anchor_mem[slot] == '0) anchor_mem[slot] = k;
          link_mem[e] = head_mem[slot];
          node_mem[e] = k;
          head_mem[slot] = kblt_pkg::IDX_W'(e);
          used_entries++;
          if (used_entries > written_entries) written_entries = used_entries;
          a.index = kblt_pkg::IDX_W'(e);
          a.node_key = k;
        end
      end
      kblt_pkg::MODE_LOOKUP: begin
        if (used_entries == 0 || !find_slot(k, slot) || anchor_mem[slot] == '0) begin
          a.status = kblt_pkg::ST_NONE;
        end else begin
          a.index = head_mem[slot];
          a.node_key = node_mem[head_mem[slot]];
        end
      end
      kblt_pkg::MODE_NEXT: begin
        if (!link_live[ei]) begin
          a.status = kblt_pkg::ST_NONE;
        end else begin
          a.index = link_mem[ei];
          a.node_key = node_mem[link_mem[ei]];
        end
      end
      default: begin
        if (used_entries != 0) clear_armed = 1'b1;
      end
    endcase
    return a;
  endfunction

  // Entered and left at a falling edge.
  task automatic send_command(input kblt_pkg::mode_t m, input logic [kblt_pkg::KEY_W-1:0] k,
                              input logic [kblt_pkg::IDX_W-1:0] ei);
    while ($urandom_range(99) < tx_idle) @(negedge clk);
    req_valid = 1'b1;
    mode = m;
    key = k;
    entry_index = ei;
    do @(posedge clk); while (req_stall);
    pending_answers.push_back(table_answer(m, k, ei));
    sent++;
    @(negedge clk);
    req_valid = 1'b0;
    mode = kblt_pkg::mode_t'($urandom_range(3));
    key = $urandom();
    entry_index = kblt_pkg::IDX_W'($urandom());
  endtask

  task automatic drain_answers();
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    rsp_stall = rx_hold || ($urandom_range(99) < rx_idle);
  end

  always @(posedge clk) begin
    answer_t a;
    if (!rst && rsp_valid && !rsp_stall) begin
      checked++;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected response status %0d index %0d key %h",
                 $time, status, index, node_key);
        errors++;
      end else begin
        a = pending_answers.pop_front();
        if (status !== a.status) begin
          $display("%0t: status expected %0d actual %0d", $time, a.status, status);
          errors++;
        end
        if (index !== a.index) begin
          $display("%0t: index expected %0d actual %0d", $time, a.index, index);
          errors++;
        end
        if (node_key !== a.node_key) begin
          $display("%0t: node_key expected %h actual %h", $time, a.node_key, node_key);
          errors++;
        end
      end
    end
  end

  task automatic test_corner_cases();
    send_command(kblt_pkg::MODE_MARK, '0, '0);
    send_command(kblt_pkg::MODE_LOOKUP, 32'h0000_0104, '0);
    send_command(kblt_pkg::MODE_ALLOC, 32'hFFFF_FFFF, '0);
    send_command(kblt_pkg::MODE_ALLOC, 32'hFFFF_FFFF, '0);
    send_command(kblt_pkg::MODE_ALLOC, 32'hFFFF_FFFC, '0);
    send_command(kblt_pkg::MODE_ALLOC, 32'h0000_0FFD, '0);
    send_command(kblt_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, '0);
    send_command(kblt_pkg::MODE_LOOKUP, 32'hFFFF_FFFC, '0);
    send_command(kblt_pkg::MODE_NEXT, '0, 12'd1);
    send_command(kblt_pkg::MODE_NEXT, '0, 12'd0);
    send_command(kblt_pkg::MODE_ALLOC, 32'h0000_0000, '0);
    send_command(kblt_pkg::MODE_LOOKUP, 32'h0000_0000, '0);
    send_command(kblt_pkg::MODE_LOOKUP, 32'h1234_5678, '0);
    send_command(kblt_pkg::MODE_MARK, '0, '0);
    send_command(kblt_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, '0);
    send_command(kblt_pkg::MODE_ALLOC, 32'h8000_0001, '0);
    send_command(kblt_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, '0);
    send_command(kblt_pkg::MODE_LOOKUP, 32'h8000_0001, '0);
    send_command(kblt_pkg::MODE_NEXT, '0, 12'd0);
    send_command(kblt_pkg::MODE_MARK, '0, '0);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < SLOTS; i++)
      send_command(kblt_pkg::MODE_ALLOC, 32'((i << 2) | 1), '0);
    send_command(kblt_pkg::MODE_ALLOC, 32'hABCD_0002, '0);
    send_command(kblt_pkg::MODE_LOOKUP, 32'hABCD_0002, '0);
    send_command(kblt_pkg::MODE_LOOKUP, 32'h0000_0FFD, '0);
    send_command(kblt_pkg::MODE_ALLOC, 32'h0000_0005, '0);
    send_command(kblt_pkg::MODE_MARK, '0, '0);
  endtask

  task automatic send_random_command();
    int                         r;
    logic [kblt_pkg::KEY_W-1:0] k;
    r = $urandom_range(99);
    k = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(47)];
    if (k == '0) k = 32'h1;
    if (r < 45) begin
      send_command(kblt_pkg::MODE_ALLOC, k, kblt_pkg::IDX_W'($urandom()));
    end else if (r < 75) begin
      send_command(kblt_pkg::MODE_LOOKUP, k, kblt_pkg::IDX_W'($urandom()));
    end else if (r < 95 && written_entries > 0) begin
      send_command(kblt_pkg::MODE_NEXT, $urandom(),
                   kblt_pkg::IDX_W'($urandom_range(written_entries - 1)));
    end else begin
      send_command(kblt_pkg::MODE_MARK, $urandom(), kblt_pkg::IDX_W'($urandom()));
    end
  endtask

  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) send_random_command();
  endtask

  task automatic test_back_pressure();
    fork
      begin
        rx_hold = 1'b1;
        repeat (400) @(negedge clk);
        rx_hold = 1'b0;
      end
      for (int i = 0; i < 60; i++) send_random_command();
    join
    drain_answers();
    test_random_traffic(20);
  endtask

  initial begin
    foreach (anchor_mem[i]) anchor_mem[i] = '0;
    foreach (head_mem[i]) head_mem[i] = '0;
    foreach (node_mem[i]) node_mem[i] = '0;
    foreach (link_mem[i]) link_mem[i] = '0;
    foreach (link_live[i]) link_live[i] = 1'b0;
    used_entries = 0;
    written_entries = 0;
    clear_armed = 1'b0;
    foreach (key_pool[i])
      key_pool[i] = ($urandom() & 32'hFFFF_F000) | ($urandom_range(7) << 2) | $urandom_range(3);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_corner_cases();
    test_table_full();
    tx_idle = 37;
    rx_idle = 64;
    test_random_traffic(80);
    tx_idle = 64;
    rx_idle = 37;
    test_random_traffic(80);
    tx_idle = 0;
    rx_idle = 0;
    test_random_traffic(60);
    test_back_pressure();
    drain_answers();
    repeat (100) @(negedge clk);
    $display("Sent %0d transactions and checked %0d responses, covering full table,",
             sent, checked);
    $display("wrapped probing, deferred frame clear and random traffic under back pressure.");
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
